// File: src/hcbp_pkg.sv
// shared types and constants of the huffman code bit packer
package hcbp_pkg;

   localparam int ACTION_W = 2;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_ENCODE = 2'd1,
      ACT_FLUSH  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_FLUSH
   } state_type;

   // code word left aligned (first bit in the msb) and its length
   typedef struct packed {
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } code_entry_type;

endpackage

// File: src/hcbp_req_if.sv
// request channel: valid/ready handshake with the load, encode or flush payload
interface hcbp_req_if import hcbp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SYMBOL_W-1:0] symbol;
   logic [CODE_W-1:0]   code_bits;
   logic [LEN_W-1:0]    code_length;

   modport source (output valid, action, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

// File: src/hcbp_rsp_if.sv
// response channel: valid/ready handshake carrying one packed byte
interface hcbp_rsp_if import hcbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: src/hcbp_code_table.sv
// code table memory: one write port, one registered read port
module hcbp_code_table import hcbp_pkg::*; #(
   parameter int SYMBOL_COUNT = 256,
   parameter int ADDR_W       = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  code_entry_type    wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output code_entry_type    rd_data
);

   code_entry_type mem_ff [SYMBOL_COUNT];
   code_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hcbp_shifter.sv
// shared left barrel shifter: aligns codes at load and drains them at encode
module hcbp_shifter import hcbp_pkg::*; (
   input  logic [CODE_W-1:0] data,
   input  logic [LEN_W-1:0]  amount,
   output logic [CODE_W-1:0] result
);

   // amounts of the full width and above give zero
   assign result = data << amount;

endmodule

// File: src/huffman_code_bit_packer_top.sv
// top level of the huffman code bit packer: sequencer, accumulator and output register
//
//   channel    dir   handshake              payload
//   req_chan   in    valid/ready            action, symbol, code_bits, code_length
//   rsp_chan   out   valid/ready            out_byte, last
//
// load: the entry is aligned by the shifter and written to the table.
// encode: the fetch state takes the table entry, then ceil((pending + length) / 8)
//   shifter steps (1..5), none for an empty code; one table read per request and at most
//   one byte out per step, a stalled output holds the step.
// flush: with bits pending, the flush state sends the zero-padded byte, marked last.
// reset clears the sequencer, accumulator and output valid; the table is not cleared.
// the output register lets a new request in while the last byte waits.
module huffman_code_bit_packer_top import hcbp_pkg::*; #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input logic        clock,
   input logic        reset,
   hcbp_req_if.sink   req_chan,
   hcbp_rsp_if.source rsp_chan
);

   localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int ACCEPT_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  pending_ff, pending_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [CODE_W-1:0] aligned_ff, aligned_in;
   logic              sym_ok_ff, sym_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic              sym_ok_now;
   logic              out_free;
   logic [CNT_W:0]    space;
   logic [CNT_W:0]    take;
   logic [CNT_W:0]    fill;
   logic              step_emit;
   logic              step_last;
   logic [LEN_W-1:0]  rem_next;
   logic [BYTE_W-1:0] merged;

   logic [CODE_W-1:0] shift_data;
   logic [LEN_W-1:0]  shift_amount;
   logic [CODE_W-1:0] shift_result;

   logic              tbl_we;
   logic              tbl_re;
   code_entry_type    tbl_wr_data;
   code_entry_type    tbl_rd_data;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign sym_ok_now     = ({1'b0, req_chan.symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // bits taken this step: up to the end of the byte or the end of the code
   assign space     = (CNT_W + 1)'(BYTE_W) - {1'b0, pending_ff};
   assign take      = (rem_ff < {{(LEN_W - CNT_W - 1){1'b0}}, space}) ?
                      rem_ff[CNT_W:0] : space;
   assign fill      = {1'b0, pending_ff} + take;
   assign step_emit = fill[CNT_W];
   assign rem_next  = rem_ff - {{(LEN_W - CNT_W - 1){1'b0}}, take};
   assign step_last = (rem_next < LEN_W'(BYTE_W));
   assign merged    = acc_ff | (aligned_ff[CODE_W-1 -: BYTE_W] >> pending_ff);

   // the shifter is free while idle, so loads align through it there
   assign shift_data   = (state_ff == ST_IDLE) ? req_chan.code_bits : aligned_ff;
   assign shift_amount = (state_ff == ST_IDLE) ?
                         LEN_W'(CODE_W) - req_chan.code_length :
                         {{(LEN_W - CNT_W - 1){1'b0}}, take};

   hcbp_shifter u_shifter (
      .data   (shift_data),
      .amount (shift_amount),
      .result (shift_result)
   );

   assign tbl_we = req_fire && (req_chan.action == ACT_LOAD) && sym_ok_now;
   assign tbl_re = req_fire && (req_chan.action == ACT_ENCODE);
   assign tbl_wr_data.bits = shift_result;
   assign tbl_wr_data.len  = (req_chan.code_length > LEN_W'(ACCEPT_LIMIT)) ?
                             '0 : req_chan.code_length;

   hcbp_code_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .ADDR_W       (ADDR_W)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (req_chan.symbol[ADDR_W-1:0]),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_re),
      .rd_addr (req_chan.symbol[ADDR_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pending_ff   <= '0;
         rem_ff       <= '0;
         sym_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pending_ff   <= pending_in;
         rem_ff       <= rem_in;
         sym_ok_ff    <= sym_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      aligned_ff  <= aligned_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      pending_in   = pending_ff;
      rem_in       = rem_ff;
      aligned_in   = aligned_ff;
      sym_ok_in    = sym_ok_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_ENCODE: begin
                     sym_ok_in = sym_ok_now;
                     state_in  = ST_FETCH;
                  end
                  ACT_FLUSH: begin
                     if (pending_ff != '0) begin
                        state_in = ST_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            aligned_in = tbl_rd_data.bits;
            rem_in     = sym_ok_ff ? tbl_rd_data.len : '0;
            state_in   = (sym_ok_ff && (tbl_rd_data.len != '0)) ? ST_STEP : ST_IDLE;
         end
         ST_STEP: begin
            if (!step_emit || out_free) begin
               aligned_in = shift_result;
               rem_in     = rem_next;
               if (step_emit) begin
                  acc_in       = '0;
                  pending_in   = '0;
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = merged;
                  rsp_last_in  = step_last;
               end else begin
                  acc_in     = merged;
                  pending_in = fill[CNT_W-1:0];
               end
               if (rem_next == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = acc_ff;
               rsp_last_in  = 1'b1;
               acc_in       = '0;
               pending_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;

`ifndef SYNTHESIS
   // the step loop never idles with an empty code
   a_step_has_bits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (rem_ff != '0))
      else $error("step state with no code bits left");

   // a flush byte is only sent when bits are pending
   a_flush_has_bits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (pending_ff != '0))
      else $error("flush state with an empty accumulator");

   // a byte without last means more bytes of this request follow
   a_not_last_continues : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_STEP) && step_emit && out_free && !step_last)
         |=> (state_ff == ST_STEP))
      else $error("encode ended after a byte not marked last");
`endif

endmodule

// File: tb/tb_huffman_code_bit_packer_top.sv
// self-checking testbench of the huffman code bit packer: table loads, code packing, flushes
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer_top import hcbp_pkg::*; ();

   localparam int MAX_CODE_LEN   = 32;
   localparam int SYMBOL_COUNT   = 256;
   localparam int RANDOM_ITEMS   = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int DIRECTED_ROWS  = 23;

   // action code the block must ignore
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } packed_byte_type;

   // typed rows carry their bytes, first byte in the top, last set on the final one
   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [SYMBOL_W-1:0] sym;
      logic [CODE_W-1:0]   bits;
      logic [LEN_W-1:0]    len;
      logic                typed;
      logic [2:0]          n_bytes;
      logic [31:0]         bytes;
   } stim_row_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hcbp_req_if req_chan ();
   hcbp_rsp_if rsp_chan ();

   huffman_code_bit_packer_top #(
      .MAX_CODE_LEN(MAX_CODE_LEN),
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: code table, byte accumulator and its fill level
   logic [CODE_W-1:0] table_word [SYMBOL_COUNT];
   logic [LEN_W-1:0]  table_len  [SYMBOL_COUNT];
   logic [BYTE_W-1:0] acc_byte = '0;
   int                acc_fill = 0;

   packed_byte_type fresh_bytes[$];
   packed_byte_type expected_bytes[$];
   logic [SYMBOL_W-1:0] written_syms[$];
   bit   is_written [SYMBOL_COUNT];

   int fault_count = 0;
   int idle_cycles = 0;
   int burst_left  = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ACT_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
      '{ACT_LOAD,   8'd0,   32'h0000_00A5, 6'd8,  1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hA500_0000},
      '{ACT_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
      '{ACT_LOAD,   8'd1,   32'h0000_007F, 6'd7,  1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
      // seven bits pending plus a full-width code
      '{ACT_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
      '{ACT_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
      '{ACT_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd0,  1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
      // overlong codes are stored with zero length
      '{ACT_LOAD,   8'd3,   32'hFFFF_FFFF, 6'd33, 1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd3,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
      '{ACT_LOAD,   8'd4,   32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd4,   32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0},
      // bits above the length must be dropped
      '{ACT_LOAD,   8'd5,   32'hFFFF_FFF0, 6'd4,  1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd5,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
      '{ACT_LOAD,   8'd6,   32'h0000_000F, 6'd7,  1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd6,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
      '{ACT_NONE,   8'hAA,  32'h5555_5555, 6'd21, 1'b1, 3'd0, 32'h0},
      '{ACT_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0},
      '{ACT_LOAD,   8'd7,   32'h0000_0000, 6'd32, 1'b1, 3'd0, 32'h0},
      '{ACT_ENCODE, 8'd7,   32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'h0000_0000}
   };

   function automatic void predict_bytes(input logic [ACTION_W-1:0] act,
                                         input logic [SYMBOL_W-1:0] sym,
                                         input logic [CODE_W-1:0]   bits,
                                         input logic [LEN_W-1:0]    len);
      fresh_bytes.delete();
      case (act)
         ACT_LOAD: begin
            if (sym < SYMBOL_COUNT) begin
               if (len > MAX_CODE_LEN) begin
                  table_word[sym] = '0;
                  table_len[sym]  = '0;
               end else begin
                  table_word[sym] = (len >= 32) ? bits : bits & ((32'd1 << len) - 32'd1);
                  table_len[sym]  = len;
               end
            end
         end
         ACT_ENCODE: begin
            if (sym < SYMBOL_COUNT) begin
               for (int i = int'(table_len[sym]); i > 0; i--) begin
                  acc_byte[7 - acc_fill] = table_word[sym][i - 1];
                  acc_fill++;
                  if (acc_fill == 8) begin
                     fresh_bytes.push_back({acc_byte, 1'b0});
                     acc_byte = '0;
                     acc_fill = 0;
                  end
               end
            end
            if (fresh_bytes.size() > 0)
               fresh_bytes[fresh_bytes.size() - 1].last = 1'b1;
         end
         ACT_FLUSH: begin
            if (acc_fill > 0)
               fresh_bytes.push_back({acc_byte, 1'b1});
            acc_byte = '0;
            acc_fill = 0;
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fault_count++;
   endtask

   // called at a falling edge, returns at the falling edge after the request is taken
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [SYMBOL_W-1:0] sym,
                               input logic [CODE_W-1:0]   bits,
                               input logic [LEN_W-1:0]    len,
                               input logic                typed,
                               input int                  n_typed,
                               input logic [31:0]         typed_bytes);
      req_chan.valid       <= 1'b1;
      req_chan.action      <= act;
      req_chan.symbol      <= sym;
      req_chan.code_bits   <= bits;
      req_chan.code_length <= len;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_bytes(act, sym, bits, len);
      if (typed) begin
         for (int k = 0; k < n_typed; k++)
            expected_bytes.push_back({typed_bytes[31 - 8*k -: 8], k == n_typed - 1});
      end else begin
         foreach (fresh_bytes[k]) expected_bytes.push_back(fresh_bytes[k]);
      end
      if (act == ACT_LOAD && !is_written[sym]) begin
         is_written[sym] = 1'b1;
         written_syms.push_back(sym);
      end
      @(negedge clock);
   endtask

   // bursts of random length with random gaps, some gaps zero
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (expected_bytes.size() != 0) @(negedge clock);
   endtask

   // receiver stall pattern, switching style at random intervals
   rx_mode_type rx_mode  = RX_OPEN;
   int          rx_left  = 0;
   int          rx_phase = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(3));
         rx_left = $urandom_range(40, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN:   rsp_chan.ready <= 1'b1;
         RX_RANDOM: rsp_chan.ready <= 1'($urandom_range(1));
         RX_SPARSE: rsp_chan.ready <= (rx_phase % 3 == 0);
         default:   rsp_chan.ready <= (rx_phase % 16 >= 12);
      endcase
   end

   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b",
                                      rsp_chan.out_byte, rsp_chan.last));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_chan.out_byte, want.data));
            if (rsp_chan.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                         rsp_chan.last, want.last, want.data));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                  counted;
      int                  r;
      logic [ACTION_W-1:0] act;
      logic [SYMBOL_W-1:0] sym;
      logic [CODE_W-1:0]   bits;
      logic [LEN_W-1:0]    len;

      req_chan.valid       = 1'b0;
      req_chan.action      = '0;
      req_chan.symbol      = '0;
      req_chan.code_bits   = '0;
      req_chan.code_length = '0;
      rsp_chan.ready       = 1'b0;
      counted = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_rows[i].act, directed_rows[i].sym, directed_rows[i].bits,
                      directed_rows[i].len, directed_rows[i].typed,
                      int'(directed_rows[i].n_bytes), directed_rows[i].bytes);
         pace_sender();
      end
      drain_results();

      while (counted < RANDOM_ITEMS) begin
         r    = $urandom_range(99);
         sym  = SYMBOL_W'($urandom_range(255));
         bits = $urandom;
         len  = LEN_W'($urandom_range(63));
         if (written_syms.size() == 0 || r < 18) begin
            act = ACT_LOAD;
            r = $urandom_range(99);
            if (r < 70)      len = LEN_W'($urandom_range(1, 12));
            else if (r < 88) len = LEN_W'($urandom_range(13, 32));
            else if (r < 94) len = 6'd0;
            else             len = LEN_W'($urandom_range(33, 63));
         end else if (r < 82) begin
            act = ACT_ENCODE;
            sym = written_syms[$urandom_range(written_syms.size() - 1)];
         end else if (r < 97) begin
            act = ACT_FLUSH;
         end else begin
            act = ACT_NONE;
         end
         send_request(act, sym, bits, len, 1'b0, 0, 32'h0);
         if (act != ACT_NONE) counted++;
         if ($urandom_range(79) == 0)
            drain_results();
         else
            pace_sender();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_count == 0 && expected_bytes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: files.f
src/hcbp_pkg.sv
src/hcbp_req_if.sv
src/hcbp_rsp_if.sv
src/hcbp_code_table.sv
src/hcbp_shifter.sv
src/huffman_code_bit_packer_top.sv
tb/tb_huffman_code_bit_packer_top.sv
